>>> rtl/amkm_pkg.sv
// Shared constants and types for the anchored multi-key matcher.
package amkm_pkg;

    // Default table geometry
    localparam int NUM_KEYS_DEF = 16;
    localparam int KEY_LEN_DEF  = 16;

    // Fixed field widths of the input word
    localparam int MODE_W = 2;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 4;
    localparam int DATA_W = 8;
    localparam int KLEN_W = 5;
    localparam int KIND_W = 2;

    // Word modes
    localparam logic [MODE_W-1:0] MODE_KEY_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY_META = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT     = 2'd2;

    // Key kinds
    localparam logic [KIND_W-1:0] KIND_PREFIX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUFFIX   = 2'd2;

    // Per-slot outcome of one text byte
    typedef struct packed {
        logic found;    // prefix or contains key completed
        logic ends;     // suffix key completed on this byte
    } t_eval_flags;

endpackage

>>> rtl/amkm_slot_eval.sv
// Per-slot update of the text state for one text byte.
module amkm_slot_eval import amkm_pkg::*; #(
    parameter int KEY_LEN = KEY_LEN_DEF,
    parameter int LW      = $clog2(KEY_LEN + 1)
) (
    input  logic [KEY_LEN*8-1:0] i_row_bytes,
    input  logic [LW-1:0]        i_len,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_meta_ok,
    input  logic [KEY_LEN-1:0]   i_hits,
    input  logic                 i_alive,
    input  logic                 i_first,
    input  logic [LW-1:0]        i_seen,
    input  logic [DATA_W-1:0]    i_data,
    output logic [KEY_LEN-1:0]   o_hits,
    output logic                 o_alive,
    output t_eval_flags          o_flags
);

    localparam int PW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    logic [LW-1:0]      kl;
    logic [KEY_LEN-1:0] hits_in;
    logic               alive_in;
    logic [KEY_LEN-1:0] eq;
    logic [KEY_LEN-1:0] mask;
    logic [KEY_LEN-1:0] hits_step;
    logic [PW-1:0]      top_idx;
    logic [PW-1:0]      seen_idx;
    logic               byte_ok;

    // Slot state on the first byte of a text is the cleared state
    assign kl       = i_meta_ok ? i_len : '0;
    assign hits_in  = i_first ? '0 : i_hits;
    assign alive_in = i_first ? 1'b1 : i_alive;
    assign top_idx  = PW'(kl - LW'(1));
    assign seen_idx = PW'(i_seen);
    assign byte_ok  = (i_row_bytes[{seen_idx, 3'b000} +: 8] == i_data);

    // Byte compare against every key position, limited to the key length
    always_comb begin
        for (int i = 0; i < KEY_LEN; i++) begin
            eq[i]   = (i_row_bytes[i*8 +: 8] == i_data);
            mask[i] = (LW'(i) < kl);
        end
    end

    // Shift-and step
    assign hits_step = ((hits_in << 1) | KEY_LEN'(1)) & eq & mask;

    always_comb begin
        o_hits        = hits_in;
        o_alive       = alive_in;
        o_flags.found = 1'b0;
        o_flags.ends  = 1'b0;
        if (kl != '0) begin
            case (i_kind)
                KIND_PREFIX: begin
                    if (alive_in && (i_seen < kl)) begin
                        if (!byte_ok) begin
                            o_alive = 1'b0;
                        end else if (i_seen == kl - LW'(1)) begin
                            o_flags.found = 1'b1;
                        end
                    end
                end
                KIND_CONTAINS: begin
                    o_hits        = hits_step;
                    o_flags.found = hits_step[top_idx];
                end
                KIND_SUFFIX: begin
                    o_hits       = hits_step;
                    o_flags.ends = hits_step[top_idx];
                end
                default: begin
                    // unknown kind never matches
                end
            endcase
        end
    end

endmodule

>>> rtl/anchored_multi_key_matcher.sv
// Top level of the anchored multi-key matcher: key table, text state and control.
//
// Key table loads (key byte, length and kind) are taken in the idle state and
// keep the input ready. A text byte closes the input: the slots are swept one
// per cycle through the key memory and the per-slot text-state memory (read,
// update, write back), then a tail state, and the last byte of a text places
// the match word in the output register once it is free. The register holds its
// word until taken while the next words are accepted. Key bytes, lengths and
// kinds are undefined until written; a slot reads as disabled from reset until
// its length and kind are written. No clearing pass is needed: the text state of
// every slot is rewritten on each byte, read as cleared on a text's first byte.
module anchored_multi_key_matcher import amkm_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int KEY_LEN  = KEY_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_data,
    input  logic [KLEN_W-1:0] i_key_length,
    input  logic [KIND_W-1:0] i_key_kind,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_matched
);

    localparam int AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PW    = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int LW    = $clog2(KEY_LEN + 1);
    localparam int BW    = KEY_LEN * 8;
    localparam int ROW_W = BW + LW + KIND_W;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_TAIL, S_PUSH} t_state;

    // Memories: key row {kind, len, bytes} and text state {alive, hits}
    logic [ROW_W-1:0]   r_key_mem [NUM_KEYS];
    logic [KEY_LEN:0]   r_txt_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_meta_ok;

    logic [ROW_W-1:0]  r_key_q;
    logic [KEY_LEN:0]  r_txt_q;
    logic              r_ok_q;

    t_state            r_state;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_p_idx;
    logic              r_p_valid;
    logic [LW-1:0]     r_seen;
    logic              r_any;
    logic              r_ends;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic              r_o_valid;
    logic              r_o_matched;

    logic              in_acc;
    logic              slot_ok;
    logic              pos_ok;
    logic              byte_we;
    logic              meta_we;
    logic [AW-1:0]     w_slot;
    logic [PW-1:0]     w_pos;
    logic [LW-1:0]     n_len;
    logic [KEY_LEN-1:0] n_hits;
    logic              n_alive;
    t_eval_flags       flags;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_matched   = r_o_matched;

    // Load decode
    assign in_acc  = i_in_valid && o_in_ready;
    assign slot_ok = (int'(i_slot) < NUM_KEYS);
    assign pos_ok  = (int'(i_position) < KEY_LEN);
    assign byte_we = in_acc && (i_mode == MODE_KEY_BYTE) && slot_ok && pos_ok;
    assign meta_we = in_acc && (i_mode == MODE_KEY_META) && slot_ok;
    assign w_slot  = AW'(i_slot);
    assign w_pos   = PW'(i_position);
    assign n_len   = (int'(i_key_length) > KEY_LEN) ? LW'(KEY_LEN) : LW'(i_key_length);

    // Key memory: byte and metadata writes, registered read
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_key_mem[w_slot][{w_pos, 3'b000} +: 8] <= i_data;
        end
        if (meta_we) begin
            r_key_mem[w_slot][BW +: LW + KIND_W] <= {i_key_kind, n_len};
        end
        r_key_q <= r_key_mem[r_idx];
    end

    // Metadata valid bits: an unwritten slot reads as disabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_ok <= '0;
        end else if (meta_we) begin
            r_meta_ok[w_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_q <= r_meta_ok[r_idx];
    end

    // Text-state memory: read ahead one slot, write back the processed one
    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_txt_mem[r_p_idx] <= {n_alive, n_hits};
        end
        r_txt_q <= r_txt_mem[r_idx];
    end

    amkm_slot_eval #(
        .KEY_LEN (KEY_LEN),
        .LW      (LW)
    ) u_eval (
        .i_row_bytes (r_key_q[BW-1:0]),
        .i_len       (r_key_q[BW +: LW]),
        .i_kind      (r_key_q[BW + LW +: KIND_W]),
        .i_meta_ok   (r_ok_q),
        .i_hits      (r_txt_q[KEY_LEN-1:0]),
        .i_alive     (r_txt_q[KEY_LEN]),
        .i_first     (r_seen == '0),
        .i_seen      (r_seen),
        .i_data      (r_data),
        .o_hits      (n_hits),
        .o_alive     (n_alive),
        .o_flags     (flags)
    );

    // Payload capture for a text byte
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_mode == MODE_TEXT)) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    // Control: sweep sequencer, text flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_p_idx     <= '0;
            r_p_valid   <= 1'b0;
            r_seen      <= '0;
            r_any       <= 1'b0;
            r_ends      <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_matched <= 1'b0;
        end else begin
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_p_valid) begin
                r_any  <= r_any | flags.found;
                r_ends <= r_ends | flags.ends;
            end
            r_p_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == MODE_TEXT)) begin
                        r_idx   <= '0;
                        r_ends  <= 1'b0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_p_valid <= 1'b1;
                    r_p_idx   <= r_idx;
                    if (r_idx == AW'(NUM_KEYS - 1)) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_TAIL: begin
                    if (r_seen < LW'(KEY_LEN)) begin
                        r_seen <= r_seen + LW'(1);
                    end
                    r_state <= r_last ? S_PUSH : S_IDLE;
                end
                S_PUSH: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_matched <= r_any | r_ends;
                        r_any       <= 1'b0;
                        r_ends      <= 1'b0;
                        r_seen      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/amkm_checker.sv
// Port-level checks for the anchored multi-key matcher, bound to the top level.
module amkm_checker import amkm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [MODE_W-1:0] i_mode,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_matched
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // A pending match word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_matched))
        else $error("output word dropped or changed while stalled");

    // A text byte starts a sweep, so the input side closes
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_TEXT) |=> !o_in_ready)
        else $error("input ready during slot sweep");

    // Table loads leave the input side open
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode != MODE_TEXT) |=> o_in_ready)
        else $error("input stalled after a table load");

    // A new result only follows the end of a text
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a finished text");

endmodule

bind anchored_multi_key_matcher amkm_checker u_amkm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_matched   (o_matched)
);

>>> verif/tb.sv
// Testbench for the anchored multi-key matcher: directed table, random key/text traffic.
`timescale 1ns / 1ps

module tb import amkm_pkg::*;;

    localparam int NUM_KEYS    = NUM_KEYS_DEF;
    localparam int KEY_LEN     = KEY_LEN_DEF;
    localparam int ITEMS       = 750;
    localparam int LIMIT       = 400000;
    localparam int DRAIN       = 64;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AT_A   = 12;
    localparam int HOLD_AT_B   = 40;

    // Codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // One input word, field by field
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
        logic [KLEN_W-1:0] len;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_matcher_word;

    // Directed row: word plus an optional hand-written match value
    typedef struct packed {
        t_matcher_word w;
        logic          chk;
        logic          want;
    } t_matcher_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode;
    logic [SLOT_W-1:0] i_slot;
    logic [POS_W-1:0]  i_position;
    logic [DATA_W-1:0] i_data;
    logic [KLEN_W-1:0] i_key_length;
    logic [KIND_W-1:0] i_key_kind;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_matched;

    anchored_multi_key_matcher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_position   (i_position),
        .i_data       (i_data),
        .i_key_length (i_key_length),
        .i_key_kind   (i_key_kind),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_matched    (o_matched)
    );

    // Matcher model state: key table plus per-text tracking
    logic [DATA_W-1:0]  key_mem [NUM_KEYS][KEY_LEN];
    logic [KEY_LEN-1:0] byte_loaded [NUM_KEYS];
    int                 len_tab [NUM_KEYS];
    logic [KIND_W-1:0]  kind_tab [NUM_KEYS];
    logic [KEY_LEN-1:0] chain [NUM_KEYS];
    logic               alive [NUM_KEYS];
    int                 seen;
    logic               found;

    logic match_q[$];   // expected match bits, oldest first
    int   errors = 0;
    int   words_sent = 0;
    int   matches_seen = 0;
    int   matches_hit = 0;
    int   cycles = 0;
    bit   calm;         // no random gaps on either side while set (the long hold-offs still apply)

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d matches still due", cycles, match_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Apply one word to the model; done is set when the word closes a text
    function automatic void step_matcher(input t_matcher_word w, output bit done,
                                         output bit hit);
        logic [KEY_LEN-1:0] eq;
        bit                 ends;
        int                 k;
        int                 i;
        int                 kl;
        done = 1'b0;
        hit  = 1'b0;
        ends = 1'b0;
        if (w.mode == MODE_KEY_BYTE) begin
            key_mem[w.slot][w.pos]     = w.data;
            byte_loaded[w.slot][w.pos] = 1'b1;
        end else if (w.mode == MODE_KEY_META) begin
            len_tab[w.slot]  = (w.len > KEY_LEN) ? KEY_LEN : int'(w.len);
            kind_tab[w.slot] = w.kind;
        end else if (w.mode == MODE_TEXT) begin
            for (k = 0; k < NUM_KEYS; k++) begin
                kl = len_tab[k];
                if (kl != 0) begin
                    if (kind_tab[k] == KIND_PREFIX) begin
                        // anchored at the start: compare at the current offset
                        if (alive[k] && seen < kl) begin
                            if (key_mem[k][seen] != w.data)
                                alive[k] = 1'b0;
                            else if (seen == kl - 1)
                                found = 1'b1;
                        end
                    end else if (kind_tab[k] == KIND_CONTAINS || kind_tab[k] == KIND_SUFFIX) begin
                        // shift-and over the key bytes
                        eq = '0;
                        for (i = 0; i < kl; i++)
                            if (key_mem[k][i] == w.data)
                                eq[i] = 1'b1;
                        chain[k] = {chain[k][KEY_LEN-2:0], 1'b1} & eq;
                        if (chain[k][kl-1]) begin
                            if (kind_tab[k] == KIND_CONTAINS)
                                found = 1'b1;
                            else
                                ends = 1'b1;
                        end
                    end
                end
            end
            if (seen < KEY_LEN)
                seen++;
            if (w.last) begin
                done = 1'b1;
                hit  = found | ends;
                for (k = 0; k < NUM_KEYS; k++) begin
                    chain[k] = '0;
                    alive[k] = 1'b1;
                end
                seen  = 0;
                found = 1'b0;
            end
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Bytes from a small alphabet so keys hit often, full range otherwise
    function automatic logic [DATA_W-1:0] pick_byte();
        if ($urandom_range(0, 9) < 7)
            return DATA_W'($urandom_range(8'h61, 8'h64));
        return DATA_W'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return KIND_PREFIX;
        if (r < 6)
            return KIND_CONTAINS;
        if (r < 9)
            return KIND_SUFFIX;
        return KIND_UNKNOWN;
    endfunction

    // Length that never enables a key byte that was not loaded yet
    function automatic logic [KLEN_W-1:0] safe_len(input logic [SLOT_W-1:0] s);
        int n;
        n = 0;
        while (n < KEY_LEN && byte_loaded[s][n])
            n++;
        if (n == KEY_LEN)
            return KLEN_W'($urandom_range(0, 31));
        return KLEN_W'($urandom_range(0, n));
    endfunction

    // All fields random; callers then fix the ones that matter
    function automatic t_matcher_word rand_word();
        t_matcher_word w;
        w.mode = MODE_W'($urandom_range(0, 2));
        w.slot = SLOT_W'($urandom);
        w.pos  = POS_W'($urandom);
        w.data = DATA_W'($urandom);
        w.len  = KLEN_W'($urandom);
        w.kind = KIND_W'($urandom);
        w.last = 1'($urandom);
        return w;
    endfunction

    function automatic t_matcher_row dir_row(input logic [MODE_W-1:0] m,
            input logic [SLOT_W-1:0] s, input logic [POS_W-1:0] p,
            input logic [DATA_W-1:0] d, input logic [KLEN_W-1:0] l,
            input logic [KIND_W-1:0] k, input logic lst, input logic chk,
            input logic want);
        t_matcher_row r;
        r.w    = '{mode: m, slot: s, pos: p, data: d, len: l, kind: k, last: lst};
        r.chk  = chk;
        r.want = want;
        return r;
    endfunction

    // Offer one word and hold it until taken; log the expected match
    task automatic send_word(input t_matcher_word w, input logic chk, input logic want);
        int  gap;
        bit  done;
        bit  hit;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= w.mode;
        i_slot       <= w.slot;
        i_position   <= w.pos;
        i_data       <= w.data;
        i_key_length <= w.len;
        i_key_kind   <= w.kind;
        i_last       <= w.last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        step_matcher(w, done, hit);
        if (done)
            match_q.push_back(chk ? want : hit);
        if (w.mode != MODE_UNUSED)
            words_sent++;
    endtask

    // Result side: random stalls, two long hold-offs, in-order compare
    initial begin : sink
        int   stall;
        logic want;
        stall       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (match_q.size() == 0) begin
                    $display("%0t: match word with nothing expected, got %0b",
                             $time, o_matched);
                    errors++;
                end else begin
                    want = match_q.pop_front();
                    if (o_matched !== want) begin
                        $display("%0t: matched mismatch, expected %0b, got %0b",
                                 $time, want, o_matched);
                        errors++;
                    end
                end
                matches_seen++;
                if (o_matched === 1'b1)
                    matches_hit++;
                // hold off long enough that the block backs up into its input
                if (matches_seen == HOLD_AT_A || matches_seen == HOLD_AT_B)
                    stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                i_out_ready <= (stall == 0);
            end
        end
    end

    // Stimulus and end of run
    initial begin : stim
        t_matcher_row      dir_tab[$];
        t_matcher_word     w;
        logic [DATA_W-1:0] txt[$];
        int                i;
        int                n;
        int                k;
        int                kl;
        int                off;
        int                mid;
        int                r;
        bit                full;

        // model reset
        for (k = 0; k < NUM_KEYS; k++) begin
            byte_loaded[k] = '0;
            len_tab[k]     = 0;
            kind_tab[k]    = KIND_PREFIX;
            chain[k]       = '0;
            alive[k]       = 1'b1;
            for (i = 0; i < KEY_LEN; i++)
                key_mem[k][i] = '0;
        end
        seen         = 0;
        found        = 1'b0;
        calm         = 1'b0;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_KEY_BYTE;
        i_slot       = '0;
        i_position   = '0;
        i_data       = '0;
        i_key_length = '0;
        i_key_kind   = KIND_PREFIX;
        i_last       = 1'b0;

        // mode, slot, pos, data, len, kind, last, typed?, typed match
        // empty table after reset: nothing can match
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   1, 1, 0));
        // unused mode is dropped
        dir_tab.push_back(dir_row(MODE_UNUSED,   4'd15, 4'd15, 8'hff, 5'd31, KIND_UNKNOWN,  1, 0, 0));
        // key "ff 00" in the top slot
        dir_tab.push_back(dir_row(MODE_KEY_BYTE, 4'd15, 4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_KEY_BYTE, 4'd15, 4'd1,  8'h00, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd2,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   1, 1, 1));
        // one byte is too short for the prefix
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   1, 1, 0));
        // suffix: hit only when the key ends the text
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd2,  KIND_SUFFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h12, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   1, 1, 1));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h12, 5'd0,  KIND_PREFIX,   1, 1, 0));
        // contains: key in the middle
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd2,  KIND_CONTAINS, 0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h12, 5'd0,  KIND_PREFIX,   1, 1, 1));
        // unknown kind never matches
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd2,  KIND_UNKNOWN,  0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   1, 1, 0));
        // edge slot/position write, slot stays disabled
        dir_tab.push_back(dir_row(MODE_KEY_BYTE, 4'd0,  4'd15, 8'ha5, 5'd0,  KIND_PREFIX,   0, 0, 0));
        // disable a slot halfway through a text
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd2,  KIND_CONTAINS, 0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'hff, 5'd0,  KIND_PREFIX,   0, 0, 0));
        dir_tab.push_back(dir_row(MODE_KEY_META, 4'd15, 4'd0,  8'h00, 5'd0,  KIND_CONTAINS, 0, 0, 0));
        dir_tab.push_back(dir_row(MODE_TEXT,     4'd0,  4'd0,  8'h00, 5'd0,  KIND_PREFIX,   1, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_tab.size(); i++)
            send_word(dir_tab[i].w, dir_tab[i].chk, dir_tab[i].want);

        // random key loads, texts and noise
        while (words_sent < ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                // load a key: bytes first, then length and kind
                k    = $urandom_range(0, NUM_KEYS - 1);
                full = ($urandom_range(0, 3) == 0);
                kl   = full ? KEY_LEN : $urandom_range(1, 6);
                for (i = 0; i < kl; i++) begin
                    w      = rand_word();
                    w.mode = MODE_KEY_BYTE;
                    w.slot = SLOT_W'(k);
                    w.pos  = POS_W'(i);
                    w.data = pick_byte();
                    send_word(w, 0, 0);
                end
                w      = rand_word();
                w.mode = MODE_KEY_META;
                w.slot = SLOT_W'(k);
                w.kind = pick_kind();
                if (full)
                    w.len = $urandom_range(0, 1) ? KLEN_W'(KEY_LEN)
                                                 : KLEN_W'($urandom_range(17, 31));
                else
                    w.len = KLEN_W'(kl);
                send_word(w, 0, 0);
            end else if (r < 80) begin
                // one text, often with a stored key planted where it counts
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                : $urandom_range(1, 12);
                txt.delete();
                repeat (n) txt.push_back(pick_byte());
                k = $urandom_range(0, NUM_KEYS - 1);
                if ($urandom_range(0, 9) < 6 && len_tab[k] != 0) begin
                    kl = len_tab[k];
                    while (txt.size() < kl)
                        txt.push_back(pick_byte());
                    if (kind_tab[k] == KIND_PREFIX)
                        off = 0;
                    else if (kind_tab[k] == KIND_SUFFIX)
                        off = txt.size() - kl;
                    else
                        off = $urandom_range(0, txt.size() - kl);
                    for (i = 0; i < kl; i++)
                        txt[off + i] = key_mem[k][i];
                    // near miss: flip one planted byte
                    if ($urandom_range(0, 4) == 0) begin
                        n = off + $urandom_range(0, kl - 1);
                        txt[n] = txt[n] ^ 8'h01;
                    end
                end
                mid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, txt.size() - 1) : -1;
                for (i = 0; i < txt.size(); i++) begin
                    w      = rand_word();
                    w.mode = MODE_TEXT;
                    w.data = txt[i];
                    w.last = (i == txt.size() - 1);
                    send_word(w, 0, 0);
                    // table change while a text is open
                    if (i == mid && !w.last) begin
                        w      = rand_word();
                        w.mode = MODE_KEY_META;
                        w.len  = safe_len(w.slot);
                        w.kind = pick_kind();
                        send_word(w, 0, 0);
                    end
                end
            end else begin
                // noise: dropped words, stray loads, disables
                w = rand_word();
                n = $urandom_range(0, 2);
                if (n == 0) begin
                    w.mode = MODE_UNUSED;
                end else if (n == 1) begin
                    w.mode = MODE_KEY_META;
                    w.len  = safe_len(w.slot);
                end else begin
                    w.mode = MODE_KEY_BYTE;
                end
                send_word(w, 0, 0);
            end
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (match_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d words (key loads, texts, table changes)", words_sent);
        $display("%0d match words checked, %0d hits, %0d mismatches",
                 matches_seen, matches_hit, errors);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
